@@ hdl/ccs_pkg.sv @@
// shared types, constants and the arctangent table for the chaos symbol spreader
// no dependencies; imported by ccs_ctrl, ccs_datapath and the top level
package ccs_pkg;

    localparam int unsigned MAX_CHIPS_DEF  = 64;
    localparam int unsigned NUM_POINTS_DEF = 4;

    // iteration counts of the shared cordic and of the bit-serial square root
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned ROOT_STEPS   = 29;
    localparam int unsigned STEP_W       = $clog2(ROOT_STEPS);
    localparam int unsigned ATAN_IDX_W   = $clog2(CORDIC_STEPS);

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CHIPS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS01  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PTS23  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAMS = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_MATCH = 2'd1;
    localparam logic [1:0] ERR_PARAM    = 2'd2;

    // angles and gain in q28
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629714;
    localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;

    localparam logic signed [15:0] FIXED_START_Q14 = 16'sd13107;
    localparam logic signed [15:0] ONE_Q14         = 16'sd16384;
    localparam logic [15:0]        PARAM_LOW_EXCL  = 16'd21299;
    localparam logic [15:0]        PARAM_HIGH_INCL = 16'd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_ACOS_INIT,
        ST_ACOS,
        ST_MUL,
        ST_WRAP,
        ST_COS_INIT,
        ST_COS,
        ST_EMIT
    } ccs_state_t;

    typedef struct packed {
        logic              load_in;
        logic              square;
        logic              root_init;
        logic              root_step;
        logic              acos_init;
        logic              vec_step;
        logic              rot_step;
        logic              mul;
        logic              wrap;
        logic              cos_init;
        logic              emit;
        logic [STEP_W-1:0] step;
    } ccs_cmd_t;

    typedef struct packed {
        logic err;
        logic last;
        logic out_free;
    } ccs_status_t;

    // atan(2^-i) in q28
    function automatic logic signed [31:0] ccs_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            4'd0:  v = 32'sd210828714;
            4'd1:  v = 32'sd124459457;
            4'd2:  v = 32'sd65760959;
            4'd3:  v = 32'sd33381290;
            4'd4:  v = 32'sd16755422;
            4'd5:  v = 32'sd8385879;
            4'd6:  v = 32'sd4193963;
            4'd7:  v = 32'sd2097109;
            4'd8:  v = 32'sd1048571;
            4'd9:  v = 32'sd524287;
            4'd10: v = 32'sd262144;
            4'd11: v = 32'sd131072;
            4'd12: v = 32'sd65536;
            4'd13: v = 32'sd32768;
            4'd14: v = 32'sd16384;
            default: v = 32'sd8192;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ccs_ctrl.sv @@
// sequencer for the chaos symbol spreader: walks each chip through
// square, root, arccosine, multiply and cosine; uses ccs_pkg
module ccs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ccs_pkg::ccs_status_t  status,
    output ccs_pkg::ccs_cmd_t     cmd
);
    import ccs_pkg::*;

    ccs_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              root_last, cordic_last;

    assign root_last   = (step_reg == STEP_W'(ROOT_STEPS - 1));
    assign cordic_last = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SQUARE;
            ST_SQUARE:    state_next = status.err ? ST_EMIT : ST_ROOT_INIT;
            ST_ROOT_INIT: state_next = ST_ROOT;
            ST_ROOT:      if (root_last) state_next = ST_ACOS_INIT;
            ST_ACOS_INIT: state_next = ST_ACOS;
            ST_ACOS:      if (cordic_last) state_next = ST_MUL;
            ST_MUL:       state_next = ST_WRAP;
            ST_WRAP:      state_next = ST_COS_INIT;
            ST_COS_INIT:  state_next = ST_COS;
            ST_COS:       if (cordic_last) state_next = ST_EMIT;
            ST_EMIT: begin
                if (status.out_free)
                    state_next = (status.err || status.last) ? ST_IDLE : ST_SQUARE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg) inside
            ST_ROOT, ST_ACOS, ST_COS: step_next = step_reg + 1'b1;
            default:                  step_next = '0;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.step = step_reg;
        unique case (state_reg)
            ST_IDLE:      cmd.load_in   = s_valid;
            ST_SQUARE:    cmd.square    = 1'b1;
            ST_ROOT_INIT: cmd.root_init = 1'b1;
            ST_ROOT:      cmd.root_step = 1'b1;
            ST_ACOS_INIT: cmd.acos_init = 1'b1;
            ST_ACOS:      cmd.vec_step  = 1'b1;
            ST_MUL:       cmd.mul       = 1'b1;
            ST_WRAP:      cmd.wrap      = 1'b1;
            ST_COS_INIT:  cmd.cos_init  = 1'b1;
            ST_COS:       cmd.rot_step  = 1'b1;
            ST_EMIT:      cmd.emit      = status.out_free;
            default:      cmd.load_in   = 1'b0;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

@@ hdl/ccs_datapath.sv @@
// datapath of the chaos symbol spreader: config registers, point match,
// square root, shared cordic, multiplier and output register; uses ccs_pkg
module ccs_datapath #(
    parameter int unsigned MAX_CHIPS  = ccs_pkg::MAX_CHIPS_DEF,
    parameter int unsigned NUM_POINTS = ccs_pkg::NUM_POINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic signed [15:0]               s_symbol_i,
    input  logic signed [15:0]               s_symbol_q,
    input  logic [14:0]                      s_start_value,
    input  ccs_pkg::ccs_cmd_t                cmd,
    output ccs_pkg::ccs_status_t             status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [15:0]               m_chip_value,
    output logic                             m_last_chip,
    output logic [1:0]                       m_error_code
);
    import ccs_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_CHIPS + 1);

    // configuration
    logic [6:0]  cps_reg;
    logic        fixed_reg;
    logic [63:0] pts01_reg, pts23_reg, params_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cps_reg    <= 7'd16;
            fixed_reg  <= 1'b0;
            pts01_reg  <= '0;
            pts23_reg  <= '0;
            params_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHIPS:  cps_reg    <= cfg_wdata[6:0];
                CFG_FIXED:  fixed_reg  <= cfg_wdata[0];
                CFG_PTS01:  pts01_reg  <= cfg_wdata;
                CFG_PTS23:  pts23_reg  <= cfg_wdata;
                CFG_PARAMS: params_reg <= cfg_wdata;
                default:    cps_reg    <= cps_reg;
            endcase
        end
    end

    // first matching point and its parameter
    logic             found;
    logic [15:0]      a_in;
    logic [63:0]      pt_word;
    logic [1:0]       err_in;
    logic [CNT_W-1:0] n_in;
    logic signed [15:0] x_in;

    always_comb begin
        found   = 1'b0;
        a_in    = '0;
        pt_word = '0;
        for (int j = 0; j < NUM_POINTS; j++) begin
            pt_word = (j < 2) ? pts01_reg : pts23_reg;
            if (!found && pt_word[(j % 2) * 32 +: 16] == s_symbol_i
                    && pt_word[(j % 2) * 32 + 16 +: 16] == s_symbol_q) begin
                found = 1'b1;
                a_in  = params_reg[j * 16 +: 16];
            end
        end
        if (!found)
            err_in = ERR_NO_MATCH;
        else if (a_in <= PARAM_LOW_EXCL || a_in > PARAM_HIGH_INCL)
            err_in = ERR_PARAM;
        else
            err_in = ERR_NONE;

        if (cps_reg == 7'd0)
            n_in = CNT_W'(1);
        else if (cps_reg > 7'(MAX_CHIPS))
            n_in = CNT_W'(MAX_CHIPS);
        else
            n_in = CNT_W'(cps_reg);

        if (fixed_reg)
            x_in = FIXED_START_Q14;
        else if (s_start_value > 15'(ONE_Q14))
            x_in = ONE_Q14;
        else
            x_in = $signed({1'b0, s_start_value});
    end

    // per-symbol state
    logic [1:0]         err_reg;
    logic [15:0]        a_reg;
    logic signed [15:0] x_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [15:0] chip_res;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            err_reg <= err_in;
            a_reg   <= a_in;
            x_reg   <= x_in;
            cnt_reg <= n_in;
        end else if (cmd.emit) begin
            if (err_reg == ERR_NONE)
                x_reg <= chip_res;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // bit-serial floor square root of (1 - x^2) scaled to q28
    logic [28:0]        sq_reg;
    logic signed [31:0] sq_full;
    logic [57:0]        rad_reg;
    logic [30:0]        rem_reg;
    logic [28:0]        root_reg;
    logic [32:0]        rem_sh, trial;
    logic               ge;

    assign sq_full = x_reg * x_reg;
    assign rem_sh  = {rem_reg, rad_reg[57:56]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (cmd.square)
            sq_reg <= sq_full[28:0];
        if (cmd.root_init) begin
            rad_reg  <= {1'b0, 29'h1000_0000 - sq_reg, 28'd0};
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg  <= {rad_reg[55:0], 2'b00};
            rem_reg  <= ge ? 31'(rem_sh - trial) : rem_sh[30:0];
            root_reg <= {root_reg[27:0], ge};
        end
    end

    // shared cordic, vectoring for arccosine and rotation for cosine
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic signed [48:0] prod_reg;
    logic signed [31:0] sh_x, sh_y, at, xs, ys;
    logic [ATAN_IDX_W-1:0] idx;
    logic               pos;
    logic signed [48:0] prod_rnd;
    logic signed [34:0] th35, th_wrap;

    assign idx  = cmd.step[ATAN_IDX_W-1:0];
    assign sh_x = cx_reg >>> idx;
    assign sh_y = cy_reg >>> idx;
    assign at   = ccs_atan(idx);
    assign pos  = cmd.vec_step ? !cy_reg[31] : cz_reg[31];
    assign xs   = {{2{x_reg[15]}}, x_reg, 14'd0};
    assign ys   = {3'b000, root_reg};

    assign prod_rnd = prod_reg + 49'sd8192;
    assign th35     = prod_rnd[48:14];

    always_comb begin
        if (th35 > 35'(PI_Q28))
            th_wrap = th35 - 35'(TWO_PI_Q28);
        else if (th35 < -35'(PI_Q28))
            th_wrap = th35 + 35'(TWO_PI_Q28);
        else
            th_wrap = th35;
    end

    always_ff @(posedge aclk) begin
        if (cmd.acos_init) begin
            if (xs[31]) begin
                cx_reg <= ys;
                cy_reg <= -xs;
                cz_reg <= HALF_PI_Q28;
            end else begin
                cx_reg <= xs;
                cy_reg <= ys;
                cz_reg <= '0;
            end
        end else if (cmd.vec_step || cmd.rot_step) begin
            cx_reg <= pos ? cx_reg + sh_y : cx_reg - sh_y;
            cy_reg <= pos ? cy_reg - sh_x : cy_reg + sh_x;
            cz_reg <= pos ? cz_reg + at   : cz_reg - at;
        end else if (cmd.wrap) begin
            cz_reg <= th_wrap[31:0];
        end else if (cmd.cos_init) begin
            cx_reg <= GAIN_Q28;
            cy_reg <= '0;
            if (cz_reg > HALF_PI_Q28) begin
                cz_reg  <= cz_reg - PI_Q28;
                neg_reg <= 1'b1;
            end else if (cz_reg < -HALF_PI_Q28) begin
                cz_reg  <= cz_reg + PI_Q28;
                neg_reg <= 1'b1;
            end else begin
                neg_reg <= 1'b0;
            end
        end
        if (cmd.mul)
            prod_reg <= $signed({1'b0, a_reg}) * cz_reg;
    end

    // round, undo the half-turn fold and clamp to [-1, 1]
    logic signed [31:0] x_rnd;
    logic signed [17:0] r18, r_sgn;

    assign x_rnd = cx_reg + 32'sd8192;
    assign r18   = x_rnd[31:14];
    assign r_sgn = neg_reg ? -r18 : r18;

    always_comb begin
        if (r_sgn > 18'sd16384)
            chip_res = ONE_Q14;
        else if (r_sgn < -18'sd16384)
            chip_res = -ONE_Q14;
        else
            chip_res = r_sgn[15:0];
    end

    // output register
    logic               m_valid_reg;
    logic signed [15:0] chip_reg;
    logic               last_reg;
    logic [1:0]         code_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (cmd.emit)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            chip_reg <= (err_reg == ERR_NONE) ? chip_res : 16'sd0;
            last_reg <= (err_reg != ERR_NONE) || (cnt_reg == CNT_W'(1));
            code_reg <= err_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chip_value = chip_reg;
    assign m_last_chip  = last_reg;
    assign m_error_code = code_reg;

    assign status.err      = (err_reg != ERR_NONE);
    assign status.last     = (cnt_reg == CNT_W'(1));
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

@@ hdl/chebyshev_chaos_symbol_spreader_unit.sv @@
// top level of the chebyshev-map chaos symbol spreader
// instantiates ccs_ctrl and ccs_datapath; uses ccs_pkg
//
// usage:
//   s_ channel takes one symbol item (i, q, start value); m_ channel gives
//   chip items, one per configured chip, the final one marked by m_last_chip.
//   a symbol matching no point, or whose map parameter lies outside (1.3, 2],
//   gives a single item with m_error_code set and m_chip_value zero.
//   configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
//   the block is idle; indexes above four are ignored.
// timing:
//   one symbol is worked on at a time. each chip goes through a square,
//   a 29-step bit-serial square root, a 16-step vectoring cordic for the
//   arccosine, a multiply, angle wrap and a 16-step rotation cordic for the
//   cosine. the block stays busy until the last chip of a symbol is emitted;
//   a symbol in error goes from the square step straight to its error item.
// reset and stalls:
//   aresetn (synchronous) restores the default configuration and idles the
//   block. a stalled m_ channel holds its item in the output register; the
//   next chip waits finished in the datapath until the register frees up.
module chebyshev_chaos_symbol_spreader_unit #(
    parameter int unsigned MAX_CHIPS  = ccs_pkg::MAX_CHIPS_DEF,
    parameter int unsigned NUM_POINTS = ccs_pkg::NUM_POINTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_symbol_i,
    input  logic signed [15:0]             s_symbol_q,
    input  logic [14:0]                    s_start_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_chip_value,
    output logic                           m_last_chip,
    output logic [1:0]                     m_error_code
);
    import ccs_pkg::*;

    ccs_cmd_t    cmd;
    ccs_status_t status;

    ccs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ccs_datapath #(
        .MAX_CHIPS  (MAX_CHIPS),
        .NUM_POINTS (NUM_POINTS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_symbol_i    (s_symbol_i),
        .s_symbol_q    (s_symbol_q),
        .s_start_value (s_start_value),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chip_value  (m_chip_value),
        .m_last_chip   (m_last_chip),
        .m_error_code  (m_error_code)
    );

    // one symbol in flight at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in flight");

    // an error item is always the only and last item of its symbol
    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |-> m_last_chip && m_chip_value == 16'sd0)
        else $error("error item not marked last or carries a chip value");

    // chips stay within [-1, 1]
    a_chip_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_chip_value <= 16'sd16384 && m_chip_value >= -16'sd16384)
        else $error("chip value outside [-1, 1]");

endmodule
